[hw/rtl/rpfa_pkg.sv]
package rpfa_pkg;

  // fixed field widths
  localparam int ADDR_W       = 24;
  localparam int HLIM_W       = 25;
  localparam int REFOUT_W     = 8;
  localparam int FREEOUT_W    = 13;
  localparam int CFG_DATA_W   = 25;
  localparam int CFG_INDEX_W  = 1;

  // page size is a power of two; the offset bits must be zero
  localparam int PAGE_BYTES   = 4096;
  localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);

  localparam logic [ADDR_W-1:0] LOW_LIMIT_RST  = '0;
  localparam logic [HLIM_W-1:0] HIGH_LIMIT_RST = HLIM_W'(1) << ADDR_W;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_INCR    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_BAD   = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LOW_LIMIT  = 1'd0,
    REG_HIGH_LIMIT = 1'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

[hw/rtl/rpfa_req_if.sv]
interface rpfa_req_if;
  logic                          valid;
  logic                          ready;
  rpfa_pkg::op_t                 opcode;
  logic [rpfa_pkg::ADDR_W-1:0]   page_addr;

  modport source (output valid, output opcode, output page_addr, input ready);
  modport sink   (input valid, input opcode, input page_addr, output ready);
endinterface

[hw/rtl/rpfa_rsp_if.sv]
interface rpfa_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [rpfa_pkg::ADDR_W-1:0]      result_addr;
  rpfa_pkg::status_t                status;
  logic [rpfa_pkg::REFOUT_W-1:0]    ref_count;
  logic [rpfa_pkg::FREEOUT_W-1:0]   free_count;

  modport source (output valid, output result_addr, output status, output ref_count,
                  output free_count, input ready);
  modport sink   (input valid, input result_addr, input status, input ref_count,
                  input free_count, output ready);
endinterface

[hw/rtl/refcounted_page_frame_allocator.sv]
// Channel | Role   | Word
// --------+--------+-----------------------------------------------------
// req     | sink   | opcode, page_addr
// rsp     | source | result_addr, status, ref_count, free_count
// cfg     | write  | cfg_wen, cfg_index (0 low_limit, 1 high_limit), cfg_data
//
// Each word has an accept cycle and an exec cycle: the accept cycle issues the
// reads of the count and stack memories, the exec cycle does the modify and
// write-back and loads rsp. After reset a clearing pass zeroes every entry of
// the count memory with req.ready low; config writes are taken during it.
// A new word is accepted while the previous result still sits in rsp; the exec
// cycle of that word waits until the rsp register is free.
module refcounted_page_frame_allocator #(
  parameter int NUM_PAGES  = 4096,
  parameter int COUNT_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  rpfa_req_if.sink                            req,
  rpfa_rsp_if.source                          rsp,
  input  logic                                cfg_wen,
  input  logic [rpfa_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rpfa_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int PG_W    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [PG_W-1:0]       LAST_PG   = PG_W'(NUM_PAGES - 1);

  // memories: counts are cleared by a sweep, the stack is never cleared
  logic [COUNT_BITS-1:0] cnt_mem [NUM_PAGES];
  logic [PG_W-1:0]       stk_mem [NUM_PAGES];

  rpfa_pkg::state_t state, state_next;

  logic [rpfa_pkg::ADDR_W-1:0] low_limit;
  logic [rpfa_pkg::HLIM_W-1:0] high_limit;

  logic [DEPTH_W-1:0] depth, depth_next;
  logic [PG_W-1:0]    clr_idx;

  // latched word
  rpfa_pkg::op_t op;
  logic [PG_W-1:0] op_pg;
  logic            op_bad;

  // memory ports
  logic                  cnt_re, cnt_we;
  logic [PG_W-1:0]       cnt_raddr, cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic                  stk_re, stk_we;
  logic [PG_W-1:0]       stk_raddr, stk_waddr;
  logic [PG_W-1:0]       stk_rdata;

  logic in_ready, accept, exec_fire, clearing;

  // rsp register
  logic                              rsp_valid;
  logic [rpfa_pkg::ADDR_W-1:0]       rsp_addr;
  rpfa_pkg::status_t                 rsp_status;
  logic [rpfa_pkg::REFOUT_W-1:0]     rsp_ref;
  logic [rpfa_pkg::FREEOUT_W-1:0]    rsp_free;

  // exec results
  logic [rpfa_pkg::ADDR_W-1:0]   x_addr;
  rpfa_pkg::status_t             x_status;
  logic [COUNT_BITS-1:0]         x_ref;
  logic                          x_cnt_we, x_stk_we;
  logic [PG_W-1:0]               x_cnt_waddr;
  logic [COUNT_BITS-1:0]         x_cnt_wdata;

  // address check on the incoming word
  logic [31:0]        in_pg_wide;
  logic               in_bad;
  logic [DEPTH_W-1:0] depth_dec;

  assign in_pg_wide = 32'(req.page_addr >> rpfa_pkg::PAGE_SHIFT);
  assign in_bad = (req.page_addr[rpfa_pkg::PAGE_SHIFT-1:0] != '0)
               || (req.page_addr < low_limit)
               || ({1'b0, req.page_addr} >= high_limit)
               || (in_pg_wide >= 32'(NUM_PAGES));
  assign depth_dec = depth - DEPTH_W'(1);

  // ---------------- state machine ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      rpfa_pkg::S_CLEAR: if (clr_idx == LAST_PG) state_next = rpfa_pkg::S_IDLE;
      rpfa_pkg::S_IDLE:  if (req.valid) state_next = rpfa_pkg::S_EXEC;
      rpfa_pkg::S_EXEC:  if (!rsp_valid || rsp.ready) state_next = rpfa_pkg::S_IDLE;
      default:           state_next = rpfa_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    exec_fire = 1'b0;
    clearing  = 1'b0;
    unique case (state)
      rpfa_pkg::S_CLEAR: clearing  = 1'b1;
      rpfa_pkg::S_IDLE:  in_ready  = 1'b1;
      rpfa_pkg::S_EXEC:  exec_fire = !rsp_valid || rsp.ready;
      default:           clearing  = 1'b0;
    endcase
  end

  assign accept    = in_ready && req.valid;
  assign req.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rpfa_pkg::S_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr_idx <= clr_idx + PG_W'(1);
    end
  end

  // ---------------- config ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit  <= rpfa_pkg::LOW_LIMIT_RST;
      high_limit <= rpfa_pkg::HIGH_LIMIT_RST;
    end else if (cfg_wen) begin
      unique case (rpfa_pkg::reg_idx_t'(cfg_index))
        rpfa_pkg::REG_LOW_LIMIT:  low_limit  <= cfg_data[rpfa_pkg::ADDR_W-1:0];
        rpfa_pkg::REG_HIGH_LIMIT: high_limit <= cfg_data[rpfa_pkg::HLIM_W-1:0];
        default:                  low_limit  <= low_limit;
      endcase
    end
  end

  // latch the word at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= req.opcode;
      op_pg  <= in_pg_wide[PG_W-1:0];
      op_bad <= in_bad;
    end
  end

  // ---------------- exec: modify ----------------
  logic [31:0]           pop_addr_wide;
  logic [COUNT_BITS-1:0] dec_cnt, inc_cnt;

  assign pop_addr_wide = 32'(stk_rdata) << rpfa_pkg::PAGE_SHIFT;
  assign dec_cnt = (cnt_rdata != '0) ? cnt_rdata - COUNT_BITS'(1) : cnt_rdata;
  assign inc_cnt = (cnt_rdata != COUNT_MAX) ? cnt_rdata + COUNT_BITS'(1) : cnt_rdata;

  always_comb begin
    x_addr      = '0;
    x_status    = rpfa_pkg::STAT_OK;
    x_ref       = '0;
    x_cnt_we    = 1'b0;
    x_stk_we    = 1'b0;
    x_cnt_waddr = op_pg;
    x_cnt_wdata = '0;
    depth_next  = depth;
    case (op)
      rpfa_pkg::OP_ALLOC: begin
        if (depth == '0) begin
          x_status = rpfa_pkg::STAT_EMPTY;
        end else begin
          depth_next  = depth_dec;
          x_cnt_we    = 1'b1;
          x_cnt_waddr = stk_rdata;
          x_cnt_wdata = COUNT_BITS'(1);
          x_addr      = pop_addr_wide[rpfa_pkg::ADDR_W-1:0];
          x_ref       = COUNT_BITS'(1);
        end
      end
      rpfa_pkg::OP_RELEASE: begin
        if (op_bad) begin
          x_status = rpfa_pkg::STAT_BAD;
        end else begin
          x_cnt_we    = 1'b1;
          x_cnt_wdata = dec_cnt;
          x_ref       = dec_cnt;
          if (dec_cnt == '0) begin
            if (32'(depth) >= 32'(NUM_PAGES)) begin
              x_status = rpfa_pkg::STAT_FULL;
            end else begin
              x_stk_we   = 1'b1;
              depth_next = depth + DEPTH_W'(1);
            end
          end
        end
      end
      rpfa_pkg::OP_INCR: begin
        if (op_bad) begin
          x_status = rpfa_pkg::STAT_BAD;
        end else begin
          x_cnt_we    = 1'b1;
          x_cnt_wdata = inc_cnt;
          x_ref       = inc_cnt;
        end
      end
      default: begin
        x_status = rpfa_pkg::STAT_OK;
      end
    endcase
  end

  // ---------------- memory ports ----------------
  assign cnt_re    = accept;
  assign cnt_raddr = in_pg_wide[PG_W-1:0];
  assign cnt_we    = clearing || (exec_fire && x_cnt_we);
  assign cnt_waddr = clearing ? clr_idx : x_cnt_waddr;
  assign cnt_wdata = clearing ? '0 : x_cnt_wdata;

  assign stk_re    = accept;
  assign stk_raddr = depth_dec[PG_W-1:0];
  assign stk_we    = exec_fire && x_stk_we;
  assign stk_waddr = depth[PG_W-1:0];

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_re) cnt_rdata <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= op_pg;
    if (stk_re) stk_rdata <= stk_mem[stk_raddr];
  end

  // ---------------- depth and rsp register ----------------
  logic [31:0] x_ref_wide, depth_next_wide;

  assign x_ref_wide      = 32'(x_ref);
  assign depth_next_wide = 32'(depth_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (exec_fire) begin
        depth     <= depth_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      rsp_addr   <= x_addr;
      rsp_status <= x_status;
      rsp_ref    <= x_ref_wide[rpfa_pkg::REFOUT_W-1:0];
      rsp_free   <= depth_next_wide[rpfa_pkg::FREEOUT_W-1:0];
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.result_addr = rsp_addr;
  assign rsp.status      = rsp_status;
  assign rsp.ref_count   = rsp_ref;
  assign rsp.free_count  = rsp_free;

endmodule
